### rtl/bmmps_pkg.sv
// Shared types and constants for the bounded min/max priority select unit.
// No dependencies; imported by the top-level module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bmmps_pkg;

    localparam int DEFAULT_STORE_DEPTH = 1024;
    localparam int DEFAULT_VALUE_BITS  = 32;

    localparam int POS_W   = 12;
    localparam int LIMIT_W = 11;
    localparam int SAMPLE_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
    localparam logic [LIMIT_W-1:0] EMIT_MAX    = 11'd2047;

    // APB register map: byte address bit 2 selects the register slot.
    localparam int           APB_ADDR_W      = 3;
    localparam logic         REG_TOTAL_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_INS,
        ST_POST,
        ST_POPD,
        ST_TRIM
    } bmmps_state_t;

endpackage : bmmps_pkg

`default_nettype wire

### rtl/bounded_min_max_priority_select_unit.sv
// Top level of the bounded min/max priority select unit: control, counters,
// APB register and the sorted pair store. Uses bmmps_pkg and bmmps_ram.
`timescale 1ns / 1ps
`default_nettype none

//  Channel  | Signals                                         | Transfer rule
//  ---------+-------------------------------------------------+-----------------------------
//  input    | in_valid, in_ready, sample_value, first_of_case | valid && ready at clk edge
//  output   | out_valid, out_ready, popped_position           | valid && ready at clk edge
//  config   | psel, penable, pwrite, paddr, pwdata, prdata    | APB write, pready tied high
//
// A transaction runs through these steps: the accept step, then the insertion walks down
// the sorted store one entry per cycle through the single read port of the RAM (with a
// separate insert step when every held pair is larger or the store is empty), then a
// pop read, a pop commit at odd positions only, and a trim step follow.
// Reset clears all counters and loads the limit register with its default of 1024; the
// store contents need no reset, since the held count marks which entries are live. A
// stalled output only delays the pop commit; the result register holds the previous
// transaction meanwhile.

module bounded_min_max_priority_select_unit
    import bmmps_pkg::*;
#(
    parameter int STORE_DEPTH = DEFAULT_STORE_DEPTH,
    parameter int VALUE_BITS  = DEFAULT_VALUE_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic signed [SAMPLE_W-1:0]  sample_value,
    input  wire logic                        first_of_case,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic             [POS_W-1:0]     popped_position,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic        [APB_ADDR_W-1:0] paddr,
    input  wire logic        [31:0]          pwdata,
    output logic             [31:0]          prdata,
    output logic                             pready
);

    // One spare entry lets a full store take the new pair before the pop and trim.
    localparam int MEM_DEPTH = STORE_DEPTH + 1;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int CW        = $clog2(STORE_DEPTH + 2);
    localparam int EW        = VALUE_BITS + POS_W;
    localparam int XW        = (VALUE_BITS > SAMPLE_W) ? VALUE_BITS : SAMPLE_W;
    localparam int SW        = (CW > LIMIT_W) ? CW : LIMIT_W;

    bmmps_state_t       state_reg, state_next;
    logic [CW-1:0]      held_reg, held_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      base_reg, base_next;
    logic [POS_W-1:0]   pos_cnt_reg, pos_cnt_next;
    logic [LIMIT_W-1:0] emitted_reg, emitted_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [EW-1:0]      entry_reg, entry_next;
    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   popped_reg, popped_next;

    logic               ram_wr_en, ram_rd_en;
    logic [AW-1:0]      ram_wr_addr, ram_rd_addr;
    logic [EW-1:0]      ram_wr_data, ram_rd_data;

    logic signed [XW-1:0] sample_ext;
    logic [VALUE_BITS-1:0] sample_key;
    logic [CW-1:0]      held_start;
    logic [POS_W-1:0]   pos_new;
    logic               in_fire, pop_fire, stored_greater;
    logic [LIMIT_W-1:0] room;
    logic [SW-1:0]      trim_held;
    logic [CW-1:0]      drops;
    logic [AW:0]        base_sum;

    // Map a logical index (0 = smallest pair) to a RAM address in the circular store.
    function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] b, input logic [CW-1:0] l);
        logic [AW:0] s;
        s = {1'b0, b} + (AW+1)'(l);
        if (s >= (AW+1)'(MEM_DEPTH))
        begin
            s = s - (AW+1)'(MEM_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    bmmps_ram #(
        .WIDTH (EW),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Offset-binary key: unsigned compare of {key, position} orders pairs by value,
    // then by position, exactly as the queue requires.
    assign sample_ext = sample_value;
    assign sample_key = sample_ext[VALUE_BITS-1:0] ^ {1'b1, {(VALUE_BITS-1){1'b0}}};

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign held_start = first_of_case ? '0 : held_reg;
    assign pos_new    = (first_of_case ? '0 : pos_cnt_reg) + POS_W'(1);
    assign stored_greater = (ram_rd_data > entry_reg);
    assign pop_fire   = (state_reg == ST_POPD) && (!out_valid_reg || out_ready);

    // Trim: keep at most (limit - emitted) pairs, and never more than the store depth.
    assign room = (limit_reg > emitted_reg) ? (limit_reg - emitted_reg) : '0;
    always_comb
    begin
        trim_held = SW'(held_reg);
        if (SW'(room) < trim_held)
        begin
            trim_held = SW'(room);
        end
        if (SW'(STORE_DEPTH) < trim_held)
        begin
            trim_held = SW'(STORE_DEPTH);
        end
    end
    assign drops    = held_reg - CW'(trim_held);
    assign base_sum = {1'b0, base_reg} + (AW+1)'(drops);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (held_start == '0) ? ST_INS : ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (!stored_greater)
                begin
                    state_next = ST_POST;
                end
                else if (idx_reg == CW'(1))
                begin
                    state_next = ST_INS;
                end
            end
            ST_INS:
            begin
                state_next = ST_POST;
            end
            ST_POST:
            begin
                state_next = pos_cnt_reg[0] ? ST_POPD : ST_TRIM;
            end
            ST_POPD:
            begin
                if (pop_fire)
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath, memory control and counter updates.
    always_comb
    begin
        held_next      = held_reg;
        idx_next       = idx_reg;
        base_next      = base_reg;
        pos_cnt_next   = pos_cnt_reg;
        emitted_next   = emitted_reg;
        entry_next     = entry_reg;
        popped_next    = popped_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = to_phys(base_reg, idx_reg);
        ram_wr_data    = entry_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = to_phys(base_reg, idx_reg - CW'(1));
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    pos_cnt_next = pos_new;
                    entry_next   = {sample_key, pos_new};
                    held_next    = held_start;
                    idx_next     = held_start;
                    if (first_of_case)
                    begin
                        emitted_next = '0;
                    end
                    // Fetch the current largest pair to start the walk down.
                    ram_rd_en   = (held_start != '0);
                    ram_rd_addr = to_phys(base_reg, held_start - CW'(1));
                end
            end
            ST_SHIFT:
            begin
                ram_wr_en = 1'b1;
                if (stored_greater)
                begin
                    // Move the larger stored pair up one slot and look one lower.
                    ram_wr_data = ram_rd_data;
                    idx_next    = idx_reg - CW'(1);
                    ram_rd_en   = (idx_reg != CW'(1));
                    ram_rd_addr = to_phys(base_reg, idx_reg - CW'(2));
                end
                else
                begin
                    held_next = held_reg + CW'(1);
                end
            end
            ST_INS:
            begin
                ram_wr_en = 1'b1;
                held_next = held_reg + CW'(1);
            end
            ST_POST:
            begin
                ram_rd_en   = pos_cnt_reg[0];
                ram_rd_addr = to_phys(base_reg, held_reg - CW'(1));
            end
            ST_POPD:
            begin
                if (pop_fire)
                begin
                    popped_next    = ram_rd_data[POS_W-1:0];
                    out_valid_next = 1'b1;
                    held_next      = held_reg - CW'(1);
                    if (emitted_reg != EMIT_MAX)
                    begin
                        emitted_next = emitted_reg + LIMIT_W'(1);
                    end
                end
            end
            ST_TRIM:
            begin
                held_next = CW'(trim_held);
                base_next = (base_sum >= (AW+1)'(MEM_DEPTH)) ?
                            AW'(base_sum - (AW+1)'(MEM_DEPTH)) : base_sum[AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            idx_reg       <= '0;
            base_reg      <= '0;
            pos_cnt_reg   <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            idx_reg       <= idx_next;
            base_reg      <= base_next;
            pos_cnt_reg   <= pos_cnt_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite && (paddr[2] == REG_TOTAL_LIMIT))
            begin
                limit_reg <= pwdata[LIMIT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg  <= entry_next;
        popped_reg <= popped_next;
    end

    assign out_valid       = out_valid_reg;
    assign popped_position = popped_reg;
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == REG_TOTAL_LIMIT) ? 32'(limit_reg) : '0;

    // The store never holds more than one pair beyond its nominal depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(MEM_DEPTH))
        else $error("held count exceeds store capacity");

    // After the trim step the count respects the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRIM) |=> (held_reg <= CW'(STORE_DEPTH)))
        else $error("trim left too many pairs");

    // A popped result is a real position, never the wrapped zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop_fire |=> (out_valid_reg && (popped_reg != '0)))
        else $error("pop produced an invalid position");

    // The walk down only runs with a nonzero index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (idx_reg != '0))
        else $error("insertion walk ran past the smallest pair");

endmodule : bounded_min_max_priority_select_unit

`default_nettype wire

### rtl/bmmps_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bmmps_ram #(
    parameter int WIDTH = 44,
    parameter int DEPTH = 1025
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : bmmps_ram

`default_nettype wire
